/* src/dnsar_pkg.sv */
// Shared types and constants for the DNS A-record response parser.
package dnsar_pkg;

    localparam int DEF_MAX_PACKET_BYTES = 1024;
    localparam int DEF_MAX_NAME_BYTES   = 256;

    localparam int NAME_OFFSET   = 12;
    localparam int QUESTION_TAIL = 4;
    localparam int FIXED_PART    = 12;
    localparam int ADDR_BYTES    = 4;
    localparam int RESULT_DEPTH  = 4;

    localparam int POS_FLAGS    = 2;
    localparam int POS_ANCOUNT_HI = 6;
    localparam int POS_ANCOUNT_LO = 7;

    localparam int RF_TYPE_FIRST = 2;
    localparam int RF_CLASS_LAST = 5;
    localparam int RF_LEN_HI     = 10;
    localparam int RF_LEN_LO     = 11;

    localparam logic [31:0] TYPE_CLASS_A = 32'h0001_0001;

    localparam logic OP_NAME     = 1'b0;
    localparam logic OP_RESPONSE = 1'b1;

    localparam logic KIND_ADDRESS = 1'b0;
    localparam logic KIND_STATUS  = 1'b1;

    typedef enum logic [2:0] {
        ST_OK,
        ST_NO_ANSWERS,
        ST_TOO_SHORT,
        ST_NAME_MISMATCH,
        ST_NOT_RESPONSE
    } status_t;

    typedef struct packed {
        logic       op;
        logic [7:0] data_byte;
        logic       last;
    } item_t;

    typedef struct packed {
        logic        kind;
        logic [31:0] address;
        logic [2:0]  status;
        logic        end_of_run;
    } result_t;

    typedef struct packed {
        logic    first_valid;
        result_t first;
        logic    second_valid;
        result_t second;
    } push_t;

endpackage

/* src/dnsar_name_store.sv */
// Question name byte memory with one write port and one registered read port.
module dnsar_name_store #(
    parameter int DEPTH = dnsar_pkg::DEF_MAX_NAME_BYTES,
    parameter int IDX_W = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_idx,
    input  logic [7:0]       wr_data,
    input  logic             rd_en,
    input  logic [IDX_W-1:0] rd_idx,
    output logic [7:0]       rd_data
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_idx] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_idx];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* src/dnsar_parser.sv */
// Input register and per-byte header, name and answer record decoding.
module dnsar_parser #(
    parameter int MAX_PACKET_BYTES = dnsar_pkg::DEF_MAX_PACKET_BYTES,
    parameter int MAX_NAME_BYTES   = dnsar_pkg::DEF_MAX_NAME_BYTES,
    parameter int NIW              = $clog2(MAX_NAME_BYTES)
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    input  logic              item_stall,
    input  dnsar_pkg::item_t  item,
    output dnsar_pkg::push_t  push,
    output logic              wr_en,
    output logic [NIW-1:0]    wr_idx,
    output logic [7:0]        wr_data,
    output logic              rd_en,
    output logic [NIW-1:0]    rd_idx,
    input  logic [7:0]        rd_data
);

    import dnsar_pkg::*;

    localparam int NLW = $clog2(MAX_NAME_BYTES + 1);
    localparam int PW  = $clog2(MAX_PACKET_BYTES + 1);
    localparam int CW  = ((PW > NLW) ? PW : NLW) + 1;

    logic            valid_reg;
    item_t           item_reg;
    logic [NLW-1:0]  name_length_reg, name_length_next;
    logic [PW-1:0]   pos_reg, pos_next;
    logic [15:0]     answer_total_reg, answer_total_next;
    logic [15:0]     answers_seen_reg, answers_seen_next;
    logic [3:0]      rfp_reg, rfp_next;
    logic [31:0]     type_class_reg, type_class_next;
    logic [15:0]     data_left_reg, data_left_next;
    logic [31:0]     accum_reg, accum_next;
    logic            qr_reg, qr_next;
    logic            mismatch_reg, mismatch_next;
    logic            name_open_reg, name_open_next;
    logic            qualify_reg, qualify_next;

    logic [CW-1:0]   pos_w, nl_w, pos_next_w, rd_off;
    logic [NLW-1:0]  nl_base;
    logic [7:0]      b;
    logic            in_name, in_records;
    logic [31:0]     tc_v;
    logic [15:0]     dl_v;
    logic [3:0]      rfp_v;
    logic            addr_hit, status_hit;
    logic [2:0]      status_code;
    result_t         addr_item, status_item;

    assign b      = item_reg.data_byte;
    assign pos_w  = CW'(pos_reg);
    assign nl_w   = CW'(name_length_reg);
    assign in_name    = (pos_w >= CW'(NAME_OFFSET)) && (pos_w < nl_w + CW'(NAME_OFFSET));
    assign in_records = pos_w >= nl_w + CW'(NAME_OFFSET + QUESTION_TAIL);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= item_valid && !item_stall;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && !item_stall)
        begin
            item_reg <= item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            name_length_reg  <= '0;
            pos_reg          <= '0;
            answer_total_reg <= '0;
            answers_seen_reg <= '0;
            rfp_reg          <= '0;
            type_class_reg   <= '0;
            data_left_reg    <= '0;
            accum_reg        <= '0;
            qr_reg           <= 1'b0;
            mismatch_reg     <= 1'b0;
            name_open_reg    <= 1'b0;
            qualify_reg      <= 1'b0;
        end
        else
        begin
            name_length_reg  <= name_length_next;
            pos_reg          <= pos_next;
            answer_total_reg <= answer_total_next;
            answers_seen_reg <= answers_seen_next;
            rfp_reg          <= rfp_next;
            type_class_reg   <= type_class_next;
            data_left_reg    <= data_left_next;
            accum_reg        <= accum_next;
            qr_reg           <= qr_next;
            mismatch_reg     <= mismatch_next;
            name_open_reg    <= name_open_next;
            qualify_reg      <= qualify_next;
        end
    end

    always_comb
    begin
        name_length_next  = name_length_reg;
        pos_next          = pos_reg;
        answer_total_next = answer_total_reg;
        answers_seen_next = answers_seen_reg;
        rfp_next          = rfp_reg;
        type_class_next   = type_class_reg;
        data_left_next    = data_left_reg;
        accum_next        = accum_reg;
        qr_next           = qr_reg;
        mismatch_next     = mismatch_reg;
        name_open_next    = name_open_reg;
        qualify_next      = qualify_reg;
        nl_base           = name_length_reg;
        tc_v              = type_class_reg;
        dl_v              = data_left_reg;
        rfp_v             = rfp_reg;
        addr_hit          = 1'b0;
        status_hit        = 1'b0;
        status_code       = ST_OK;
        wr_en             = 1'b0;
        wr_idx            = name_length_reg[NIW-1:0];

        if (valid_reg)
        begin
            if (item_reg.op == OP_NAME)
            begin
                pos_next          = '0;
                answer_total_next = '0;
                answers_seen_next = '0;
                rfp_next          = '0;
                type_class_next   = '0;
                data_left_next    = '0;
                accum_next        = '0;
                qr_next           = 1'b0;
                mismatch_next     = 1'b0;
                qualify_next      = 1'b0;
                nl_base           = name_open_reg ? name_length_reg : '0;
                name_length_next  = nl_base;
                wr_idx            = nl_base[NIW-1:0];
                if (CW'(nl_base) < CW'(MAX_NAME_BYTES))
                begin
                    wr_en            = 1'b1;
                    name_length_next = nl_base + 1'b1;
                end
                name_open_next = !item_reg.last;
            end
            else
            begin
                name_open_next = 1'b0;
                if (pos_w < CW'(MAX_PACKET_BYTES))
                begin
                    pos_next = pos_reg + 1'b1;
                    if (pos_w == CW'(POS_FLAGS) && b[7])
                    begin
                        qr_next = 1'b1;
                    end
                    if (pos_w == CW'(POS_ANCOUNT_HI))
                    begin
                        answer_total_next = {b, 8'h00};
                    end
                    if (pos_w == CW'(POS_ANCOUNT_LO))
                    begin
                        answer_total_next = {answer_total_reg[15:8], b};
                    end
                    if (in_name)
                    begin
                        if (b != rd_data)
                        begin
                            mismatch_next = 1'b1;
                        end
                    end
                    else if (in_records)
                    begin
                        if (rfp_reg < 4'(FIXED_PART))
                        begin
                            if (!(rfp_reg == '0 && answers_seen_reg >= answer_total_reg))
                            begin
                                if (rfp_reg == '0)
                                begin
                                    answers_seen_next = answers_seen_reg + 1'b1;
                                    tc_v = '0;
                                    dl_v = '0;
                                end
                                if (rfp_reg >= 4'(RF_TYPE_FIRST)
                                    && rfp_reg <= 4'(RF_CLASS_LAST))
                                begin
                                    tc_v = {tc_v[23:0], b};
                                end
                                if (rfp_reg == 4'(RF_LEN_HI))
                                begin
                                    dl_v = {b, 8'h00};
                                end
                                if (rfp_reg == 4'(RF_LEN_LO))
                                begin
                                    dl_v = {dl_v[15:8], b};
                                end
                                rfp_v = rfp_reg + 1'b1;
                                if (rfp_v == 4'(FIXED_PART))
                                begin
                                    qualify_next = 1'b0;
                                    if (dl_v == '0)
                                    begin
                                        rfp_v = '0;
                                    end
                                    else
                                    begin
                                        qualify_next = (tc_v == TYPE_CLASS_A)
                                            && (dl_v == 16'(ADDR_BYTES));
                                        accum_next = '0;
                                    end
                                end
                                type_class_next = tc_v;
                                data_left_next  = dl_v;
                                rfp_next        = rfp_v;
                            end
                        end
                        else
                        begin
                            accum_next     = {accum_reg[23:0], b};
                            data_left_next = data_left_reg - 1'b1;
                            if (data_left_next == '0)
                            begin
                                addr_hit     = qualify_reg && qr_reg && !mismatch_reg;
                                qualify_next = 1'b0;
                                rfp_next     = '0;
                            end
                        end
                    end
                end
                if (item_reg.last)
                begin
                    status_hit = 1'b1;
                    if (CW'(pos_next) < nl_w + CW'(NAME_OFFSET + QUESTION_TAIL))
                    begin
                        status_code = ST_TOO_SHORT;
                    end
                    else if (mismatch_next)
                    begin
                        status_code = ST_NAME_MISMATCH;
                    end
                    else if (!qr_next)
                    begin
                        status_code = ST_NOT_RESPONSE;
                    end
                    else if (answer_total_next == '0)
                    begin
                        status_code = ST_NO_ANSWERS;
                    end
                    else
                    begin
                        status_code = ST_OK;
                    end
                    pos_next          = '0;
                    answer_total_next = '0;
                    answers_seen_next = '0;
                    rfp_next          = '0;
                    type_class_next   = '0;
                    data_left_next    = '0;
                    accum_next        = '0;
                    qr_next           = 1'b0;
                    mismatch_next     = 1'b0;
                    qualify_next      = 1'b0;
                end
            end
        end
    end

    assign addr_item.kind         = KIND_ADDRESS;
    assign addr_item.address      = {accum_reg[23:0], b};
    assign addr_item.status       = ST_OK;
    assign addr_item.end_of_run   = 1'b0;
    assign status_item.kind       = KIND_STATUS;
    assign status_item.address    = '0;
    assign status_item.status     = status_code;
    assign status_item.end_of_run = 1'b1;

    assign push.first_valid  = addr_hit || status_hit;
    assign push.first        = addr_hit ? addr_item : status_item;
    assign push.second_valid = addr_hit && status_hit;
    assign push.second       = status_item;

    assign wr_data    = b;
    assign pos_next_w = CW'(pos_next);
    assign rd_off     = pos_next_w - CW'(NAME_OFFSET);
    assign rd_en      = (pos_next_w >= CW'(NAME_OFFSET)) && (rd_off < CW'(MAX_NAME_BYTES));
    assign rd_idx     = rd_off[NIW-1:0];

endmodule

/* src/dnsar_result_fifo.sv */
// Result queue taking up to two results a cycle, with input back-pressure.
module dnsar_result_fifo (
    input  logic               clk,
    input  logic               rst_n,
    input  dnsar_pkg::push_t   push,
    output logic               result_valid,
    input  logic               result_stall,
    output dnsar_pkg::result_t result,
    output logic               item_stall
);

    import dnsar_pkg::*;

    localparam int IW  = $clog2(RESULT_DEPTH);
    localparam int CNW = $clog2(RESULT_DEPTH + 1);

    result_t         slots_reg [RESULT_DEPTH];
    logic [IW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [IW-1:0]   rd_ptr_reg;
    logic [CNW-1:0]  count_reg, count_next;
    logic [1:0]      n_push;
    logic            pop;

    assign pop          = result_valid && !result_stall;
    assign n_push       = 2'(push.first_valid) + 2'(push.second_valid);
    assign count_next   = count_reg + CNW'(n_push) - CNW'(pop);
    assign wr_ptr_next  = wr_ptr_reg + IW'(n_push);
    assign result_valid = count_reg != '0;
    assign result       = slots_reg[rd_ptr_reg];
    assign item_stall   = count_next > CNW'(RESULT_DEPTH - 2);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            count_reg  <= count_next;
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.first_valid)
        begin
            slots_reg[wr_ptr_reg] <= push.first;
        end
        if (push.second_valid)
        begin
            slots_reg[wr_ptr_reg + 1'b1] <= push.second;
        end
    end

endmodule

/* src/dns_a_record_response_parser.sv */
// Each result is decoded from the input register and offered from the result queue.
// Throughput: one byte per cycle while item_stall is low, set by the decode after the
// input register and a four-entry result queue that takes up to two results per cycle.
// Name compare reads the name memory one byte ahead, so the stored byte is ready in time.
// Reset clears all packet and name state; name memory contents stay undefined until loaded.
module dns_a_record_response_parser #(
    parameter int MAX_PACKET_BYTES = dnsar_pkg::DEF_MAX_PACKET_BYTES,
    parameter int MAX_NAME_BYTES   = dnsar_pkg::DEF_MAX_NAME_BYTES
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_stall,
    input  dnsar_pkg::item_t   item,
    output logic               result_valid,
    input  logic               result_stall,
    output dnsar_pkg::result_t result
);

    import dnsar_pkg::*;

    localparam int NIW = $clog2(MAX_NAME_BYTES);

    push_t           push;
    logic            wr_en;
    logic [NIW-1:0]  wr_idx;
    logic [7:0]      wr_data;
    logic            rd_en;
    logic [NIW-1:0]  rd_idx;
    logic [7:0]      rd_data;

    dnsar_parser #(
        .MAX_PACKET_BYTES (MAX_PACKET_BYTES),
        .MAX_NAME_BYTES   (MAX_NAME_BYTES),
        .NIW              (NIW)
    ) u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .push       (push),
        .wr_en      (wr_en),
        .wr_idx     (wr_idx),
        .wr_data    (wr_data),
        .rd_en      (rd_en),
        .rd_idx     (rd_idx),
        .rd_data    (rd_data)
    );

    dnsar_name_store #(
        .DEPTH (MAX_NAME_BYTES),
        .IDX_W (NIW)
    ) u_name_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_idx  (wr_idx),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_idx  (rd_idx),
        .rd_data (rd_data)
    );

    dnsar_result_fifo u_result_fifo (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .item_stall   (item_stall)
    );

endmodule

/* src/dnsar_checker.sv */
// Port-level checks for the DNS A-record response parser, bound to the top level.
module dnsar_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               item_valid,
    input logic               item_stall,
    input dnsar_pkg::item_t   item,
    input logic               result_valid,
    input logic               result_stall,
    input dnsar_pkg::result_t result
);

    import dnsar_pkg::*;

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("result changed while stalled");

    a_status_shape: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.kind == KIND_STATUS
            |-> result.end_of_run && result.address == '0)
        else $error("status transfer carries address or lacks end mark");

    a_result_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(item_valid && !item_stall, 2))
        else $error("result offered without a byte transferred two cycles before");

    a_empty_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !result_valid |-> !item_stall)
        else $error("input stalled while result queue is empty");

endmodule

bind dns_a_record_response_parser dnsar_checker u_checker (.*);
